FILE: hdl/bfa_pkg.sv
// bfa_pkg: shared constants, command codes and control/status structs
// for the bitmap first-free allocator. No dependencies.
package bfa_pkg;

   localparam int BITMAP_BYTES = 128;
   localparam int INDEX_W = 10;
   localparam int LIMIT_W = 8;
   localparam int INDEX_FIELD_BYTES = (1 << INDEX_W) / 8;

   // bitmap is held as words of 32 bits, scanned one word per cycle
   localparam int WORD_BITS = 32;
   localparam int WORD_BYTES = WORD_BITS / 8;
   localparam int NUM_WORDS = (BITMAP_BYTES + WORD_BYTES - 1) / WORD_BYTES;
   localparam int WADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BPOS_W = $clog2(WORD_BITS);
   localparam int BSEL_W = $clog2(WORD_BYTES);

   localparam int SCAN_CAP = (BITMAP_BYTES < INDEX_FIELD_BYTES) ? BITMAP_BYTES
                                                                  : INDEX_FIELD_BYTES;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(128);

   localparam logic CMD_FIND  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic load;       // latch the accepted item
      logic rd_ptr;     // read word at scan pointer, advance pointer
      logic rd_idx;     // read word addressed by the item's bit index
      logic wr_en;      // write modified word back
      logic rsp_found;  // load result with found set
      logic rsp_none;   // load result with found clear
   } bfa_cmd_type;

   typedef struct packed {
      logic range_ok;
      logic limit_zero;
      logic hit;
      logic last;
      logic rsp_free;
   } bfa_stat_type;

endpackage

FILE: hdl/bfa_datapath.sv
// bfa_datapath: bitmap word memory, scan pointer, zero search,
// read-modify-write, scan-length register and result register. Uses bfa_pkg.
module bfa_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  bfa_pkg::bfa_cmd_type        cmd,
   output bfa_pkg::bfa_stat_type       stat,
   input  logic                        req_cmd,
   input  logic [bfa_pkg::INDEX_W-1:0] req_bit_index,
   input  logic                        req_write_value,
   input  logic                        csr_wr_en,
   input  logic [bfa_pkg::LIMIT_W-1:0] csr_wr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic [bfa_pkg::INDEX_W-1:0] rsp_free_index
);
   import bfa_pkg::*;

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] vld_ff;

   logic                 item_cmd_ff;
   logic [INDEX_W-1:0]   item_idx_ff;
   logic                 item_val_ff;
   logic [WADDR_W-1:0]   ptr_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_vld_ff;
   logic [WADDR_W-1:0]   rd_addr_ff;
   logic [LIMIT_W-1:0]   limit_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [INDEX_W-1:0]   rsp_index_ff;

   logic                 rd_en;
   logic [WADDR_W-1:0]   rd_addr;
   logic [WADDR_W-1:0]   item_word;
   logic [LIMIT_W-1:0]   scan_len;
   logic [LIMIT_W-1:0]   scan_len_m1;
   logic [WORD_BITS-1:0] cur_word;
   logic [WORD_BITS-1:0] masked;
   logic [WORD_BITS-1:0] new_word;
   logic [BPOS_W-1:0]    zpos;
   logic [BPOS_W-1:0]    wpos;
   logic                 rsp_load;

   assign item_word = item_idx_ff[BPOS_W +: WADDR_W];
   assign rd_en = cmd.rd_ptr | cmd.rd_idx;
   assign rd_addr = cmd.rd_idx ? item_word : ptr_ff;

   // scan length capped by bitmap size and index field reach
   assign scan_len = (32'(limit_ff) > SCAN_CAP) ? LIMIT_W'(SCAN_CAP) : limit_ff;
   assign scan_len_m1 = scan_len - LIMIT_W'(1);

   assign cur_word = rd_vld_ff ? rd_data_ff : '0;

   // bytes past the scan length look full
   always_comb begin
      masked = cur_word;
      for (int j = 0; j < WORD_BYTES; j++) begin
         if (LIMIT_W'({rd_addr_ff, BSEL_W'(j)}) >= scan_len) begin
            masked[j*8 +: 8] = 8'hFF;
         end
      end
   end

   always_comb begin
      zpos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!masked[i]) begin
            zpos = BPOS_W'(i);
         end
      end
   end

   assign wpos = (item_cmd_ff == CMD_WRITE) ? item_idx_ff[BPOS_W-1:0] : zpos;

   always_comb begin
      new_word = cur_word;
      new_word[wpos] = item_val_ff;
   end

   assign stat.range_ok   = (32'(item_idx_ff >> BPOS_W) < NUM_WORDS);
   assign stat.limit_zero = (scan_len == '0);
   assign stat.hit        = (masked != '1);
   assign stat.last       = (rd_addr_ff == scan_len_m1[BSEL_W +: WADDR_W]);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_load = cmd.rsp_found | cmd.rsp_none;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         ptr_ff       <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            vld_ff[rd_addr_ff] <= 1'b1;
         end
         if (cmd.load) begin
            ptr_ff <= '0;
         end else if (cmd.rd_ptr) begin
            ptr_ff <= ptr_ff + WADDR_W'(1);
         end
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_cmd_ff <= req_cmd;
         item_idx_ff <= req_bit_index;
         item_val_ff <= req_write_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (cmd.rsp_found) begin
         rsp_found_ff <= 1'b1;
         rsp_index_ff <= INDEX_W'({rd_addr_ff, zpos});
      end else if (cmd.rsp_none) begin
         rsp_found_ff <= 1'b0;
         rsp_index_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[rd_addr_ff] <= new_word;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_free_index = rsp_index_ff;

endmodule

FILE: hdl/bfa_ctrl.sv
// bfa_ctrl: state machine sequencing item accept, word scan, bit write-back
// and result hand-off. Uses bfa_pkg command and status structs.
module bfa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_cmd,
   output logic                  req_ready,
   input  bfa_pkg::bfa_stat_type stat,
   output bfa_pkg::bfa_cmd_type  cmd
);
   import bfa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_READ,
      ST_WR_MOD,
      ST_FIND_START,
      ST_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_cmd == CMD_WRITE) ? ST_WR_READ : ST_FIND_START;
            end
         end
         ST_WR_READ: begin
            if (stat.range_ok) begin
               cmd.rd_idx = 1'b1;
               state_in = ST_WR_MOD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WR_MOD: begin
            cmd.wr_en = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FIND_START: begin
            if (stat.limit_zero) begin
               if (stat.rsp_free) begin
                  cmd.rsp_none = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.rd_ptr = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // hold the read word while the result register is still occupied
            if (stat.hit) begin
               if (stat.rsp_free) begin
                  cmd.wr_en = 1'b1;
                  cmd.rsp_found = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (stat.last) begin
               if (stat.rsp_free) begin
                  cmd.rsp_none = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.rd_ptr = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/bitmap_first_free_allocator_core.sv
// bitmap_first_free_allocator_core: find-first-zero slot allocator over a 1024-bit map.
// Write item: accepted, word read, word written back, then ready for the next item.
// Find item: a start state, then one 32-bit word checked per cycle until a free bit or
// the last word in the scan length; a full result register holds the result off, and a
// zero scan length skips the scan. Ready for the next item as the result is registered.
// Sync reset marks every word unwritten (reads as zero), scan length 128; no clearing pass.
module bitmap_first_free_allocator_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd,
   input  logic [bfa_pkg::INDEX_W-1:0] req_bit_index,
   input  logic                        req_write_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic [bfa_pkg::INDEX_W-1:0] rsp_free_index,
   input  logic                        csr_wr_en,
   input  logic [bfa_pkg::LIMIT_W-1:0] csr_wr_data
);
   import bfa_pkg::*;

   bfa_cmd_type  cmd;
   bfa_stat_type stat;

   bfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bfa_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_cmd         (req_cmd),
      .req_bit_index   (req_bit_index),
      .req_write_value (req_write_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_free_index  (rsp_free_index)
   );

   // a pending result is never overwritten
   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_found || cmd.rsp_none) |-> (!rsp_valid || rsp_ready))
      else $error("result register loaded while occupied");

   // a write item never produces a result
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_cmd == CMD_WRITE) |=>
         (!cmd.rsp_found && !cmd.rsp_none) ##1 (!cmd.rsp_found && !cmd.rsp_none))
      else $error("write item produced a result");

   // found results always come with a bitmap write-back
   a_found_writes: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_found |-> (cmd.wr_en && stat.hit))
      else $error("found result without write-back");

endmodule

FILE: tb/bitmap_first_free_allocator_core_tb.sv
`timescale 1ns / 100ps
// bitmap_first_free_allocator_core_tb: checks find and write items and the scan length
// register against a slot map kept in the bench. Depends on bfa_pkg and the core.
module bitmap_first_free_allocator_core_tb;
   import bfa_pkg::*;

   localparam int MAP_BYTES = BITMAP_BYTES;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SEGMENTS = 8;
   localparam int SEG_ITEMS = 75;
   localparam int SCRIPT_ROWS = 25;

   typedef enum logic {ROW_ITEM, ROW_LEN} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [LIMIT_W-1:0] len;
      logic               cmd;
      logic [INDEX_W-1:0] idx;
      logic               val;
      logic               typed;
      logic               found;
      logic [INDEX_W-1:0] at;
   } script_row_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] at;
   } grant_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_cmd = CMD_FIND;
   logic [INDEX_W-1:0]  req_bit_index = '0;
   logic                req_write_value = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_found;
   logic [INDEX_W-1:0]  rsp_free_index;
   logic                csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]  csr_wr_data = '0;

   // hand-typed expectation riding along with the item
   logic                req_typed = 1'b0;
   logic                req_exp_found = 1'b0;
   logic [INDEX_W-1:0]  req_exp_at = '0;

   logic [7:0]          slot_map [MAP_BYTES];
   int                  scan_len;
   grant_type           expected_grants [$];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   int                  idle_pct = 0;
   int                  stall_pct = 0;
   int                  hold_reqs = 0;
   int                  hold_served = 0;
   int                  hold_left = 0;

   int                  seg_len [SEGMENTS] = '{2, 1, 4, 128, 3, 255, 8, 2};
   int                  seg_idle [4] = '{0, 76, 0, 32};
   int                  seg_stall [4] = '{0, 0, 76, 32};

   script_row_type script [SCRIPT_ROWS] = '{
      '{ROW_ITEM, 8'd0,   CMD_FIND,  10'd0,    1'b1, 1'b1, 1'b1, 10'd0},
      '{ROW_ITEM, 8'd0,   CMD_FIND,  10'd0,    1'b1, 1'b1, 1'b1, 10'd1},
      '{ROW_ITEM, 8'd0,   CMD_FIND,  10'd0,    1'b0, 1'b1, 1'b1, 10'd2},
      '{ROW_ITEM, 8'd0,   CMD_FIND,  10'd1023, 1'b1, 1'b1, 1'b1, 10'd2},
      '{ROW_ITEM, 8'd0,   CMD_WRITE, 10'd1023, 1'b1, 1'b0, 1'b0, 10'd0},
      '{ROW_ITEM, 8'd0,   CMD_WRITE, 10'd0,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_ITEM, 8'd0,   CMD_FIND,  10'd0,    1'b1, 1'b1, 1'b1, 10'd0},
      '{ROW_LEN,  8'd1,   CMD_FIND,  10'd0,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_ITEM, 8'd0,   CMD_WRITE, 10'd3,    1'b1, 1'b0, 1'b0, 10'd0},
      '{ROW_ITEM, 8'd0,   CMD_WRITE, 10'd4,    1'b1, 1'b0, 1'b0, 10'd0},
      '{ROW_ITEM, 8'd0,   CMD_WRITE, 10'd5,    1'b1, 1'b0, 1'b0, 10'd0},
      '{ROW_ITEM, 8'd0,   CMD_WRITE, 10'd6,    1'b1, 1'b0, 1'b0, 10'd0},
      '{ROW_ITEM, 8'd0,   CMD_WRITE, 10'd7,    1'b1, 1'b0, 1'b0, 10'd0},
      '{ROW_ITEM, 8'd0,   CMD_FIND,  10'd0,    1'b1, 1'b1, 1'b0, 10'd0},
      '{ROW_LEN,  8'd0,   CMD_FIND,  10'd0,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_ITEM, 8'd0,   CMD_FIND,  10'd1023, 1'b1, 1'b1, 1'b0, 10'd0},
      '{ROW_LEN,  8'd255, CMD_FIND,  10'd0,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_ITEM, 8'd0,   CMD_FIND,  10'd0,    1'b1, 1'b1, 1'b1, 10'd8},
      '{ROW_ITEM, 8'd0,   CMD_WRITE, 10'd1016, 1'b1, 1'b0, 1'b0, 10'd0},
      '{ROW_ITEM, 8'd0,   CMD_WRITE, 10'd1023, 1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_ITEM, 8'd0,   CMD_FIND,  10'd0,    1'b0, 1'b1, 1'b1, 10'd9},
      '{ROW_ITEM, 8'd0,   CMD_WRITE, 10'd682,  1'b1, 1'b0, 1'b0, 10'd0},
      '{ROW_ITEM, 8'd0,   CMD_WRITE, 10'd341,  1'b1, 1'b0, 1'b0, 10'd0},
      '{ROW_LEN,  8'd128, CMD_FIND,  10'd0,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_ITEM, 8'd0,   CMD_FIND,  10'd0,    1'b1, 1'b0, 1'b0, 10'd0}
   };

   bitmap_first_free_allocator_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_bit_index   (req_bit_index),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_free_index  (rsp_free_index),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void store_slot(input logic [INDEX_W-1:0] pos, input logic v);
      if (int'(pos >> 3) < MAP_BYTES) begin
         slot_map[pos[INDEX_W-1:3]][pos[2:0]] = v;
      end
   endfunction

   // lowest clear bit within the scan window, then mark it with v
   function automatic void claim_slot(input logic v, output logic hit,
                                      output logic [INDEX_W-1:0] at);
      int limit;
      limit = scan_len;
      if (limit > MAP_BYTES) limit = MAP_BYTES;
      if (limit > SCAN_CAP) limit = SCAN_CAP;
      hit = 1'b0;
      at = '0;
      for (int b = 0; b < limit && !hit; b++) begin
         for (int k = 0; k < 8 && !hit; k++) begin
            if (!slot_map[b][k]) begin
               hit = 1'b1;
               at = INDEX_W'(b * 8 + k);
               slot_map[b][k] = v;
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, expected_grants.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: long hold-off on request, random stalls otherwise
   always @(posedge clock) begin
      if (hold_served != hold_reqs) begin
         hold_served <= hold_reqs;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      grant_type want;
      logic hit;
      logic [INDEX_W-1:0] at;
      if (!reset) begin
         // results first: one accepted at this edge belongs to an older item
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               $display("%0t: unexpected result found=%0d index=%0d", $time,
                        rsp_found, rsp_free_index);
               mismatch_count++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_found !== want.found) begin
                  $display("%0t: found expected %0d actual %0d", $time,
                           want.found, rsp_found);
                  mismatch_count++;
               end
               if (rsp_free_index !== want.at) begin
                  $display("%0t: free_index expected %0d actual %0d", $time,
                           want.at, rsp_free_index);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_WRITE) begin
               store_slot(req_bit_index, req_write_value);
            end else begin
               claim_slot(req_write_value, hit, at);
               if (req_typed) begin
                  want.found = req_exp_found;
                  want.at = req_exp_at;
               end else begin
                  want.found = hit;
                  want.at = at;
               end
               expected_grants.push_back(want);
            end
         end
      end
   end

   task automatic send_item(input logic c, input logic [INDEX_W-1:0] i, input logic v,
                            input logic typed, input logic ef,
                            input logic [INDEX_W-1:0] ea);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_bit_index <= i;
      req_write_value <= v;
      req_typed <= typed;
      req_exp_found <= ef;
      req_exp_at <= ea;
      do @(posedge clock); while (!req_ready);
   endtask

   // wait for every outstanding result, then let a trailing write item finish
   task automatic drain_results();
      req_valid <= 1'b0;
      // wait an edge so a find accepted at the last edge is already queued
      @(posedge clock);
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_scan_len(input int len);
      csr_wr_en <= 1'b1;
      csr_wr_data <= LIMIT_W'(len);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      scan_len = len;
   endtask

   task automatic send_random_item();
      int span;
      logic [INDEX_W-1:0] idx;
      span = (scan_len > SCAN_CAP) ? SCAN_CAP : scan_len;
      if ($urandom_range(99) < 50) begin
         send_item(CMD_FIND, INDEX_W'($urandom_range(1023)), $urandom_range(9) != 0,
                   1'b0, 1'b0, '0);
      end else begin
         // mostly hit the scanned window so freed slots get reused
         if (span > 0 && $urandom_range(9) < 8) begin
            idx = INDEX_W'($urandom_range(span * 8 - 1));
         end else begin
            idx = INDEX_W'($urandom_range(1023));
         end
         send_item(CMD_WRITE, idx, $urandom_range(99) >= 65, 1'b0, 1'b0, '0);
      end
   endtask

   initial begin
      for (int b = 0; b < MAP_BYTES; b++) slot_map[b] = '0;
      scan_len = int'(LIMIT_RESET);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r]) begin
         if (script[r].kind == ROW_LEN) begin
            drain_results();
            write_scan_len(int'(script[r].len));
         end else begin
            send_item(script[r].cmd, script[r].idx, script[r].val, script[r].typed,
                      script[r].found, script[r].at);
         end
      end

      // receiver holds off while finds keep coming, so the input backs up
      hold_reqs <= hold_reqs + 1;
      repeat (12) send_item(CMD_FIND, INDEX_W'($urandom_range(1023)), 1'b1,
                            1'b0, 1'b0, '0);
      drain_results();

      for (int s = 0; s < SEGMENTS; s++) begin
         drain_results();
         write_scan_len(seg_len[s]);
         idle_pct = seg_idle[s % 4];
         stall_pct = seg_stall[s % 4];
         repeat (SEG_ITEMS) send_random_item();
      end
      drain_results();

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
